FILE: sv/spi_burst_register_read_core_defines.svh
// Assertion macros shared by the checker of the SPI burst read core.
`ifndef SPI_BURST_REGISTER_READ_CORE_DEFINES_SVH
`define SPI_BURST_REGISTER_READ_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define SBRR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SBRR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/sbrr_pkg.sv
// Types and constants shared by the SPI burst register read core.
`default_nettype none

package sbrr_pkg;

  localparam int BYTE_BITS = 8;
  localparam int BIT_POS_W = $clog2(BYTE_BITS);
  localparam logic [BYTE_BITS-1:0] READ_FLAG  = 8'h80;
  localparam logic [BYTE_BITS-1:0] DUMMY_BYTE = 8'h55;

  localparam int S_TDATA_W = 24;
  localparam int M_TDATA_W = 16;

  typedef enum logic {
    FUNC_START = 1'b0,
    FUNC_TICK  = 1'b1
  } func_t;

  typedef struct packed {
    func_t          func;
    logic [6:0]     reg_addr;
    logic [7:0]     read_len;
    logic           target;
    logic           miso_accel;
    logic           miso_gyro;
  } item_t;

  typedef struct packed {
    logic           sck_pulse;
    logic           mosi_accel;
    logic           mosi_gyro;
    logic           byte_valid;
    logic [7:0]     rx_byte;
    logic           last;
    logic           busy_res;
  } result_t;

  // Handshake status of a register stage as seen by its neighbor.
  typedef struct packed {
    logic valid;
    logic ready;
  } stage_ctl_t;

endpackage

`default_nettype wire

FILE: sv/sbrr_in_reg.sv
// Input register stage holding one accepted item.
`default_nettype none

module sbrr_in_reg (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           s_valid,
  input  wire sbrr_pkg::item_t s_item,
  input  wire logic           take,
  output sbrr_pkg::stage_ctl_t ctl,
  output sbrr_pkg::item_t      item
);
  import sbrr_pkg::*;

  logic valid;

  always_comb begin
    ctl.valid = valid;
    ctl.ready = !valid || take;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.ready) begin
      valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ready && s_valid) begin
      item <= s_item;
    end
  end

endmodule

`default_nettype wire

FILE: sv/sbrr_engine.sv
// Transfer state and the per-item SPI bit logic.
`default_nettype none

module sbrr_engine (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            fire,
  input  wire sbrr_pkg::item_t item,
  output sbrr_pkg::result_t    res
);
  import sbrr_pkg::*;

  logic                 active;
  logic                 slave_sel;
  logic                 in_addr_phase;
  logic [BIT_POS_W-1:0] bit_pos;
  logic [7:0]           bytes_left;
  logic [BYTE_BITS-1:0] tx_shift;
  logic [BYTE_BITS-1:0] rx_shift;

  logic                 active_next;
  logic                 slave_sel_next;
  logic                 in_addr_phase_next;
  logic [BIT_POS_W-1:0] bit_pos_next;
  logic [7:0]           bytes_left_next;
  logic [BYTE_BITS-1:0] tx_shift_next;
  logic [BYTE_BITS-1:0] rx_shift_next;

  always_comb begin
    logic                 miso;
    logic [BYTE_BITS-1:0] rx_new;
    logic                 tx_bit;
    logic [7:0]           left_after;

    res                = '0;
    active_next        = active;
    slave_sel_next     = slave_sel;
    in_addr_phase_next = in_addr_phase;
    bit_pos_next       = bit_pos;
    bytes_left_next    = bytes_left;
    tx_shift_next      = tx_shift;
    rx_shift_next      = rx_shift;

    miso       = slave_sel ? item.miso_gyro : item.miso_accel;
    rx_new     = {rx_shift[BYTE_BITS-2:0], miso};
    tx_bit     = tx_shift[BYTE_BITS-1];
    left_after = in_addr_phase ? bytes_left : (bytes_left - 8'd1);

    unique case (item.func)
      FUNC_START: begin
        slave_sel_next     = item.target;
        bytes_left_next    = item.read_len;
        tx_shift_next      = READ_FLAG | {1'b0, item.reg_addr};
        rx_shift_next      = '0;
        bit_pos_next       = '0;
        in_addr_phase_next = 1'b1;
        active_next        = 1'b1;
        res.busy_res       = 1'b1;
      end
      FUNC_TICK: begin
        if (active) begin
          res.sck_pulse  = 1'b1;
          res.mosi_gyro  = slave_sel && tx_bit;
          res.mosi_accel = !slave_sel && tx_bit;
          rx_shift_next  = rx_new;
          tx_shift_next  = {tx_shift[BYTE_BITS-2:0], 1'b0};
          if (bit_pos == BIT_POS_W'(BYTE_BITS - 1)) begin
            bit_pos_next       = '0;
            in_addr_phase_next = 1'b0;
            bytes_left_next    = left_after;
            rx_shift_next      = '0;
            if (!in_addr_phase) begin
              res.byte_valid = 1'b1;
              res.rx_byte    = rx_new;
            end
            if (left_after == 8'd0) begin
              res.last    = 1'b1;
              active_next = 1'b0;
            end else begin
              tx_shift_next = DUMMY_BYTE;
            end
          end else begin
            bit_pos_next = bit_pos + BIT_POS_W'(1);
          end
          res.busy_res = active_next;
        end
      end
      default: begin
        res = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active        <= 1'b0;
      slave_sel     <= 1'b0;
      in_addr_phase <= 1'b0;
      bit_pos       <= '0;
      bytes_left    <= '0;
      tx_shift      <= '0;
      rx_shift      <= '0;
    end else if (fire) begin
      active        <= active_next;
      slave_sel     <= slave_sel_next;
      in_addr_phase <= in_addr_phase_next;
      bit_pos       <= bit_pos_next;
      bytes_left    <= bytes_left_next;
      tx_shift      <= tx_shift_next;
      rx_shift      <= rx_shift_next;
    end
  end

endmodule

`default_nettype wire

FILE: sv/sbrr_out_reg.sv
// Result register stage in front of the output channel.
`default_nettype none

module sbrr_out_reg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire sbrr_pkg::result_t load_res,
  input  wire logic              m_ready,
  output sbrr_pkg::stage_ctl_t   ctl,
  output sbrr_pkg::result_t      res
);
  import sbrr_pkg::*;

  logic valid;

  always_comb begin
    ctl.valid = valid;
    ctl.ready = !valid || m_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.ready) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ready && load) begin
      res <= load_res;
    end
  end

endmodule

`default_nettype wire

FILE: sv/spi_burst_register_read_core.sv
// Top level of the SPI mode 0 burst register read master.
//
// Usage: every input item is either a start command (tuser = 0) that latches
// the register address, the data byte count and the slave, or a tick
// (tuser = 1) that stands for one SCK period. For each tick the block reports
// whether SCK pulsed, the bit to drive on the selected slave's MOSI and, at
// the end of each data byte, the byte assembled from the sampled MISO bits.
// The byte received during the address phase is dropped; tlast marks the
// tick that finishes the whole transfer. Every item gives exactly one result.
// The result is registered: an accepted item waits in an input register, and
// the bit logic feeds a result register that offers it on the output channel.
// Throughput is one item per cycle while the receiver keeps tready high; the
// transfer state updates once per item, so a tick may follow a start or
// another tick at once.
// Reset (rst, synchronous, active high) empties both register stages and
// returns the transfer state to idle. When the receiver holds tready low,
// the result register holds its item, the input register fills behind it,
// and s_axis_tready drops only once both stages hold an item.
`default_nettype none

module spi_burst_register_read_core (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata: reg_addr[6:0], read_len[14:7], target[15], miso_accel[16],
  // miso_gyro[17], zero padding[23:18]
  input  wire logic [sbrr_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // tuser: func (0 = start, 1 = tick)
  input  wire logic                           s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // tdata: sck_pulse[0], mosi_accel[1], mosi_gyro[2], rx_byte[10:3],
  // busy_res[11], zero padding[15:12]
  output logic [sbrr_pkg::M_TDATA_W-1:0]      m_axis_tdata,
  // tuser: byte_valid
  output logic                                m_axis_tuser,
  output logic                                m_axis_tlast
);
  import sbrr_pkg::*;

  item_t      s_item;
  item_t      cur_item;
  stage_ctl_t in_ctl;
  stage_ctl_t out_ctl;
  result_t    eng_res;
  result_t    out_res;
  logic       fire;

  // Unpack the slave-side item.
  always_comb begin
    s_item.func       = func_t'(s_axis_tuser);
    s_item.reg_addr   = s_axis_tdata[6:0];
    s_item.read_len   = s_axis_tdata[14:7];
    s_item.target     = s_axis_tdata[15];
    s_item.miso_accel = s_axis_tdata[16];
    s_item.miso_gyro  = s_axis_tdata[17];
  end

  // The held item is processed when the result register can take its result.
  assign fire          = in_ctl.valid && out_ctl.ready;
  assign s_axis_tready = in_ctl.ready;

  sbrr_in_reg u_in_reg (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_axis_tvalid),
    .s_item  (s_item),
    .take    (fire),
    .ctl     (in_ctl),
    .item    (cur_item)
  );

  sbrr_engine u_engine (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .item (cur_item),
    .res  (eng_res)
  );

  sbrr_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (fire),
    .load_res (eng_res),
    .m_ready  (m_axis_tready),
    .ctl      (out_ctl),
    .res      (out_res)
  );

  // Pack the master-side result.
  always_comb begin
    m_axis_tvalid = out_ctl.valid;
    m_axis_tdata  = {4'b0000, out_res.busy_res, out_res.rx_byte,
                     out_res.mosi_gyro, out_res.mosi_accel, out_res.sck_pulse};
    m_axis_tuser  = out_res.byte_valid;
    m_axis_tlast  = out_res.last;
  end

endmodule

`default_nettype wire

FILE: sv/sbrr_checker.sv
// Port-level checker for the SPI burst read core, bound to its top level.
`default_nettype none
`include "spi_burst_register_read_core_defines.svh"

module sbrr_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           m_axis_tvalid,
  input wire logic                           m_axis_tready,
  input wire logic [sbrr_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input wire logic                           m_axis_tuser,
  input wire logic                           m_axis_tlast
);
  import sbrr_pkg::*;

  `SBRR_ASSERT_NOW(a_byte_needs_pulse, m_axis_tvalid && m_axis_tuser, m_axis_tdata[0], "data byte reported without an SCK pulse")
  `SBRR_ASSERT_NOW(a_last_ends_busy, m_axis_tvalid && m_axis_tlast, m_axis_tdata[0] && !m_axis_tdata[11], "transfer end must pulse SCK and drop busy")
  `SBRR_ASSERT_NOW(a_rx_zero_idle, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[10:3] == 8'd0, "received byte must be zero when no byte completed")
  `SBRR_ASSERT_NOW(a_one_mosi, m_axis_tvalid, !(m_axis_tdata[1] && m_axis_tdata[2]), "both MOSI lines driven high")
  `SBRR_ASSERT_NEXT(a_hold_stall, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

endmodule

bind spi_burst_register_read_core sbrr_checker u_sbrr_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

FILE: verif/spi_burst_register_read_core_tb.sv
// Self-checking testbench for the SPI burst register read core.
module spi_burst_register_read_core_tb;
  import sbrr_pkg::*;

  // Cycles with no accepted item on either side before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 500;
  // Input items that do real work (starts and ticks of a running transfer).
  localparam int WORK_ITEM_TARGET = 1750;
  localparam int MAX_PRINTED_ERRORS = 100;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic                 s_axis_tuser = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 m_axis_tuser;
  logic                 m_axis_tlast;

  spi_burst_register_read_core dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Shadow copy of the transfer state of the master.
  logic       xfer_active = 1'b0;
  logic       xfer_slave = 1'b0;
  logic       addr_phase = 1'b0;
  logic [2:0] bit_count = '0;
  logic [7:0] bytes_remaining = '0;
  logic [7:0] mosi_shift = '0;
  logic [7:0] miso_shift = '0;

  result_t expected_results[$];
  int      error_count = 0;
  int      results_seen = 0;
  int      work_items = 0;
  bit      source_gaps = 1'b1;
  bit      sink_stalls = 1'b1;
  int      sink_wait = 0;

  // Advances the shadow state by one accepted item and returns the result it must give.
  function automatic result_t next_spi_result(input item_t it);
    result_t res;
    logic    miso_bit;
    res = '0;
    if (it.func == FUNC_START) begin
      // A start always wins, even in the middle of a transfer.
      xfer_slave      = it.target;
      bytes_remaining = it.read_len;
      mosi_shift      = READ_FLAG | {1'b0, it.reg_addr};
      miso_shift      = '0;
      bit_count       = '0;
      addr_phase      = 1'b1;
      xfer_active     = 1'b1;
      res.busy_res    = 1'b1;
    end else if (xfer_active) begin
      miso_bit = xfer_slave ? it.miso_gyro : it.miso_accel;
      res.sck_pulse = 1'b1;
      if (xfer_slave) begin
        res.mosi_gyro = mosi_shift[7];
      end else begin
        res.mosi_accel = mosi_shift[7];
      end
      miso_shift = {miso_shift[6:0], miso_bit};
      mosi_shift = mosi_shift << 1;
      if (bit_count == 3'(BYTE_BITS - 1)) begin
        bit_count = '0;
        // The byte clocked in alongside the address is thrown away.
        if (addr_phase) begin
          addr_phase = 1'b0;
        end else begin
          res.byte_valid  = 1'b1;
          res.rx_byte     = miso_shift;
          bytes_remaining = bytes_remaining - 8'd1;
        end
        if (bytes_remaining == 8'd0) begin
          res.last    = 1'b1;
          xfer_active = 1'b0;
        end else begin
          mosi_shift = DUMMY_BYTE;
        end
        miso_shift = '0;
      end else begin
        bit_count = bit_count + 3'd1;
      end
      res.busy_res = xfer_active;
    end
    return res;
  endfunction

  function automatic item_t start_item(input logic [6:0] addr, input logic [7:0] len,
                                       input logic target);
    item_t it;
    it          = '0;
    it.func     = FUNC_START;
    it.reg_addr = addr;
    it.read_len = len;
    it.target   = target;
    return it;
  endfunction

  function automatic item_t tick_item(input logic miso_a, input logic miso_g);
    item_t it;
    it            = '0;
    it.func       = FUNC_TICK;
    it.miso_accel = miso_a;
    it.miso_gyro  = miso_g;
    return it;
  endfunction

  // Every field random, including the ones the block should ignore.
  function automatic item_t random_item(input func_t f);
    item_t it;
    it.func       = f;
    it.reg_addr   = 7'($urandom_range(0, 127));
    it.read_len   = 8'($urandom_range(0, 255));
    it.target     = 1'($urandom_range(0, 1));
    it.miso_accel = 1'($urandom_range(0, 1));
    it.miso_gyro  = 1'($urandom_range(0, 1));
    return it;
  endfunction

  // Offers one item and returns at the edge where it is taken. The valid is left
  // high so that a following item can go out back to back.
  task automatic send_item(input item_t it);
    int gap;
    bit was_busy;
    gap = source_gaps ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.func;
    s_axis_tdata  <= {6'b0, it.miso_gyro, it.miso_accel, it.target, it.read_len,
                      it.reg_addr};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    was_busy = xfer_active;
    expected_results.push_back(next_spi_result(it));
    if (it.func == FUNC_START || was_busy) work_items++;
  endtask

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    if (error_count < MAX_PRINTED_ERRORS)
      $display("ERROR result %0d: %s is %0h, expected %0h", results_seen, what, got, want);
    error_count++;
  endtask

  // Random stalls on the result side, with stretches of full-rate draining.
  always @(posedge clk) begin
    if (m_axis_tvalid && m_axis_tready) begin
      if ($urandom_range(0, 49) == 0) sink_stalls = !sink_stalls;
      sink_wait = sink_stalls ? $urandom_range(0, 19) : 0;
    end else if (sink_wait > 0) begin
      sink_wait = sink_wait - 1;
    end
    m_axis_tready <= (sink_wait == 0);
  end

  // Compares each accepted result with the oldest prediction.
  always @(posedge clk) begin
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result, tdata low byte", m_axis_tdata[7:0], 8'h00);
      end else begin
        want = expected_results.pop_front();
        if (m_axis_tdata[0] !== want.sck_pulse)
          report_mismatch("sck_pulse", 8'(m_axis_tdata[0]), 8'(want.sck_pulse));
        if (m_axis_tdata[1] !== want.mosi_accel)
          report_mismatch("mosi_accel", 8'(m_axis_tdata[1]), 8'(want.mosi_accel));
        if (m_axis_tdata[2] !== want.mosi_gyro)
          report_mismatch("mosi_gyro", 8'(m_axis_tdata[2]), 8'(want.mosi_gyro));
        if (m_axis_tdata[10:3] !== want.rx_byte)
          report_mismatch("rx_byte", m_axis_tdata[10:3], want.rx_byte);
        if (m_axis_tdata[11] !== want.busy_res)
          report_mismatch("busy_res", 8'(m_axis_tdata[11]), 8'(want.busy_res));
        if (m_axis_tdata[15:12] !== 4'b0)
          report_mismatch("tdata padding", 8'(m_axis_tdata[15:12]), 8'h00);
        if (m_axis_tuser !== want.byte_valid)
          report_mismatch("byte_valid", 8'(m_axis_tuser), 8'(want.byte_valid));
        if (m_axis_tlast !== want.last)
          report_mismatch("last", 8'(m_axis_tlast), 8'(want.last));
      end
      results_seen++;
    end
  end

  // Ends a hung run.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("simulation failed");
    $finish;
  end

  // A tick before any start must do nothing at all.
  task automatic test_idle_tick();
    send_item(tick_item(1'b1, 1'b1));
  endtask

  // Longest burst to the gyroscope with the highest address, cut short by a new start.
  task automatic test_abandoned_burst();
    send_item(start_item(7'h7F, 8'hFF, 1'b1));
    send_item(tick_item(1'b1, 1'b0));
    send_item(tick_item(1'b0, 1'b1));
    send_item(tick_item(1'b1, 1'b1));
    send_item(start_item(7'h00, 8'h00, 1'b0));
  endtask

  // Address byte only: the eighth tick ends the transfer with no data byte.
  // Then one more tick, which falls on an idle master.
  task automatic test_zero_length();
    for (int i = 0; i < BYTE_BITS; i++)
      send_item(tick_item(1'(i), 1'(~i)));
    send_item(tick_item(1'b0, 1'b1));
  endtask

  // Mostly well-formed bursts with random data; some are cut short, some run
  // on into idle ticks, and now and then raw random items are mixed in.
  task automatic test_random_bursts();
    int kind;
    int len;
    int ticks;
    while (work_items < WORK_ITEM_TARGET) begin
      source_gaps = ($urandom_range(0, 3) != 0);
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        repeat ($urandom_range(1, 6))
          send_item(random_item(func_t'($urandom_range(0, 1))));
      end else begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 4);
        send_item(start_item(7'($urandom_range(0, 127)), 8'(len), 1'($urandom_range(0, 1))));
        ticks = BYTE_BITS * (len + 1);
        if (kind == 1) ticks = $urandom_range(1, ticks);
        else if (kind == 2) ticks = ticks + $urandom_range(1, 3);
        repeat (ticks)
          send_item(tick_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_idle_tick();
    test_abandoned_burst();
    test_zero_length();
    test_random_bursts();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    // Let any stray result show up before the verdict.
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
